// File: src/lcd_gram_window_access_defines.svh
// ----------------------------------------------------------------------------
// lcd gram window access: assertion macros
// shared concurrent assertion forms, clocked on the block clock
// ----------------------------------------------------------------------------
`ifndef LCD_GRAM_WINDOW_ACCESS_DEFINES_SVH
`define LCD_GRAM_WINDOW_ACCESS_DEFINES_SVH

// checked outside reset only
`define LGWA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define LGWA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/lgwa_pkg.sv
// ----------------------------------------------------------------------------
// lgwa_pkg
// types, constants and helpers of the lcd gram window access block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgwa_pkg;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;

   localparam int PIXEL_W  = 16;
   localparam int ADDR_X_W = 9;
   localparam int ADDR_Y_W = 8;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   // entry mode bits
   localparam int EM_HORIZ_FIRST_BIT = 3;
   localparam int EM_Y_INC_BIT       = 4;
   localparam int EM_X_INC_BIT       = 5;
   localparam int EM_BGR_BIT         = 12;

   localparam logic [CSR_W-1:0]    ENTRY_MODE_RST = 16'h1038;
   localparam logic [ADDR_X_W-1:0] WIN_X_LAST_RST = 9'h13F;
   localparam logic [ADDR_Y_W-1:0] WIN_Y_LAST_RST = 8'hEF;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_X_FIRST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_X_LAST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_Y_FIRST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_Y_LAST = 3'd4;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_SET_X = 2'd2,
      CMD_SET_Y = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PIXEL_W-1:0]   value;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   read_pixel;
      logic [ADDR_X_W-1:0]  addr_x;
      logic [ADDR_Y_W-1:0]  addr_y;
   } rsp_word_type;

   // red and blue trade places unless bgr order is selected
   function automatic logic [PIXEL_W-1:0] color_order(input logic [PIXEL_W-1:0] v,
                                                      input logic bgr);
      logic [PIXEL_W-1:0] swapped;
      swapped = {v[4:0], v[10:5], v[15:11]};
      return bgr ? v : swapped;
   endfunction

endpackage

// File: src/lcd_gram_window_access.sv
// ----------------------------------------------------------------------------
// lcd_gram_window_access
// graphics ram port: pixel store with a windowed x/y address counter
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                              word
//   request   in         req_valid, req_stall, req_data     cmd, value
//   response  out        rsp_valid, rsp_stall, rsp_data     read_pixel, addr_x, addr_y
//   csr       in         csr_we, csr_index, csr_wdata       register write
//
// write and address commands may follow back to back.
// a pixel read waits in ST_READ: the memory port returns its data registered.
// after reset the store is cleared one pixel a cycle, all SCREEN_WIDTH*SCREEN_HEIGHT
// pixels (76800 at the defaults); req_stall stays high until it is done.
// the response register frees one word a cycle; while it is held by rsp_stall
// no new request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_gram_window_access #(
   parameter int SCREEN_WIDTH  = lgwa_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = lgwa_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lgwa_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lgwa_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_we,
   input  logic [lgwa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgwa_pkg::CSR_W-1:0]          csr_wdata
);

   import lgwa_pkg::*;

`include "lcd_gram_window_access_defines.svh"

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CXW   = $clog2(SCREEN_WIDTH);
   localparam int CYW   = $clog2(SCREEN_HEIGHT);
   localparam int AXW   = (CXW > CYW) ? CXW : CYW;
   localparam int XMAX  = SCREEN_WIDTH - 1;
   localparam int YMAX  = SCREEN_HEIGHT - 1;

   localparam logic [AW-1:0]  LAST_CELL = AW'(DEPTH - 1);
   localparam logic [AW-1:0]  ROW_PITCH = AW'(SCREEN_WIDTH);
   localparam logic [CXW-1:0] X_LIMIT   = CXW'(XMAX);
   localparam logic [CYW-1:0] Y_LIMIT   = CYW'(YMAX);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_READY = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   // one step of an axis: {wrap, new position}
   function automatic logic [AXW:0] step_axis(input logic [AXW-1:0] pos,
                                              input logic inc,
                                              input logic [AXW-1:0] first,
                                              input logic [AXW-1:0] last);
      logic [AXW:0] nxt;
      logic [AXW:0] res;
      nxt = {1'b0, pos} + {{AXW{1'b0}}, 1'b1};
      if (inc) begin
         if (nxt > {1'b0, last}) begin
            res = {1'b1, first};
         end else begin
            res = nxt;
         end
      end else begin
         if (pos == '0 || (pos - {{(AXW-1){1'b0}}, 1'b1}) < first) begin
            res = {1'b1, last};
         end else begin
            res = {1'b0, pos - {{(AXW-1){1'b0}}, 1'b1}};
         end
      end
      return res;
   endfunction

   // control state
   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CXW-1:0]        count_x_ff, count_x_in;
   logic [CYW-1:0]        count_y_ff, count_y_in;
   logic [CXW-1:0]        shadow_x_ff, shadow_x_in;
   logic [CYW-1:0]        shadow_y_ff, shadow_y_in;

   // csr registers
   logic [CSR_W-1:0]      entry_mode_ff;
   logic [ADDR_X_W-1:0]   win_x_first_ff;
   logic [ADDR_X_W-1:0]   win_x_last_ff;
   logic [ADDR_Y_W-1:0]   win_y_first_ff;
   logic [ADDR_Y_W-1:0]   win_y_last_ff;

   // payload
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic [PIXEL_W-1:0]    rd_data_ff;

   // pixel store
   logic [PIXEL_W-1:0]    gram [DEPTH];

   logic                  req_take;
   logic                  rsp_take;
   logic                  rsp_load;
   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   logic [AW-1:0]         cell_addr;
   logic [PIXEL_W-1:0]    mem_wdata;
   logic                  bgr;
   logic [CXW-1:0]        x_first, x_last;
   logic [CYW-1:0]        y_first, y_last;
   logic [CXW-1:0]        set_x;
   logic [CYW-1:0]        set_y;
   logic [AXW:0]          x_step, y_step;
   logic [CXW-1:0]        adv_x;
   logic [CYW-1:0]        adv_y;

   assign bgr       = entry_mode_ff[EM_BGR_BIT];
   assign req_stall = (state_ff != ST_READY) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // window bounds held to the display
   assign x_first = (int'(win_x_first_ff) > XMAX) ? X_LIMIT : CXW'(win_x_first_ff);
   assign x_last  = (int'(win_x_last_ff)  > XMAX) ? X_LIMIT : CXW'(win_x_last_ff);
   assign y_first = (int'(win_y_first_ff) > YMAX) ? Y_LIMIT : CYW'(win_y_first_ff);
   assign y_last  = (int'(win_y_last_ff)  > YMAX) ? Y_LIMIT : CYW'(win_y_last_ff);

   assign set_x = (int'(req_data.value) > XMAX) ? X_LIMIT : CXW'(req_data.value);
   assign set_y = (int'(req_data.value) > YMAX) ? Y_LIMIT : CYW'(req_data.value);

   assign x_step = step_axis(AXW'(count_x_ff), entry_mode_ff[EM_X_INC_BIT],
                             AXW'(x_first), AXW'(x_last));
   assign y_step = step_axis(AXW'(count_y_ff), entry_mode_ff[EM_Y_INC_BIT],
                             AXW'(y_first), AXW'(y_last));

   // the leading axis steps, the other one only on its wrap
   always_comb begin
      if (entry_mode_ff[EM_HORIZ_FIRST_BIT]) begin
         adv_x = CXW'(x_step[AXW-1:0]);
         adv_y = x_step[AXW] ? CYW'(y_step[AXW-1:0]) : count_y_ff;
      end else begin
         adv_y = CYW'(y_step[AXW-1:0]);
         adv_x = y_step[AXW] ? CXW'(x_step[AXW-1:0]) : count_x_ff;
      end
   end

   // counters never leave the display, so the cell needs no clamp
   assign cell_addr = AW'(count_y_ff) * ROW_PITCH + AW'(count_x_ff);
   assign mem_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : cell_addr;
   assign mem_we    = (state_ff == ST_CLEAR) || (req_take && req_data.cmd == CMD_WRITE);
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : color_order(req_data.value, bgr);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      count_x_in  = count_x_ff;
      count_y_in  = count_y_ff;
      shadow_x_in = shadow_x_ff;
      shadow_y_in = shadow_y_ff;
      rsp_load    = 1'b0;
      rsp_word_in.read_pixel = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + {{(AW-1){1'b0}}, 1'b1};
            if (clr_addr_ff == LAST_CELL) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            if (req_take) begin
               rsp_load = (req_data.cmd != CMD_READ);
               unique case (req_data.cmd)
                  CMD_WRITE: begin
                     count_x_in = adv_x;
                     count_y_in = adv_y;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_SET_X: begin
                     shadow_x_in = set_x;
                     count_x_in  = set_x;
                     count_y_in  = shadow_y_ff;
                  end
                  CMD_SET_Y: begin
                     shadow_y_in = set_y;
                     count_x_in  = shadow_x_ff;
                     count_y_in  = set_y;
                  end
                  default: begin
                     state_in = ST_READY;
                  end
               endcase
            end
         end
         ST_READ: begin
            // output slot was free when the read was taken
            rsp_load = 1'b1;
            rsp_word_in.read_pixel = color_order(rd_data_ff, bgr);
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      rsp_word_in.addr_x = ADDR_X_W'(count_x_in);
      rsp_word_in.addr_y = ADDR_Y_W'(count_y_in);

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         count_x_ff   <= '0;
         count_y_ff   <= '0;
         shadow_x_ff  <= '0;
         shadow_y_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         count_x_ff   <= count_x_in;
         count_y_ff   <= count_y_in;
         shadow_x_ff  <= shadow_x_in;
         shadow_y_ff  <= shadow_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_mode_ff  <= ENTRY_MODE_RST;
         win_x_first_ff <= '0;
         win_x_last_ff  <= WIN_X_LAST_RST;
         win_y_first_ff <= '0;
         win_y_last_ff  <= WIN_Y_LAST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRY_MODE:  entry_mode_ff  <= csr_wdata;
            CSR_WIN_X_FIRST: win_x_first_ff <= csr_wdata[ADDR_X_W-1:0];
            CSR_WIN_X_LAST:  win_x_last_ff  <= csr_wdata[ADDR_X_W-1:0];
            CSR_WIN_Y_FIRST: win_y_first_ff <= csr_wdata[ADDR_Y_W-1:0];
            CSR_WIN_Y_LAST:  win_y_last_ff  <= csr_wdata[ADDR_Y_W-1:0];
            default: begin
               entry_mode_ff <= entry_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // single port store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         gram[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= gram[mem_addr];
   end

   `LGWA_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff), "reset did not restart the clearing pass")
   `LGWA_ASSERT(a_read_waits, (req_take && req_data.cmd == CMD_READ) |=> (state_ff == ST_READ && !rsp_valid_ff), "read did not wait for memory data")
   `LGWA_ASSERT(a_read_lands, (state_ff == ST_READ) |=> (rsp_valid_ff && state_ff == ST_READY), "read data did not reach the response")
   `LGWA_ASSERT(a_cmd_answers, (req_take && req_data.cmd != CMD_READ) |=> rsp_valid_ff, "command gave no response word")
   `LGWA_ASSERT(a_in_screen, (int'(count_x_ff) <= XMAX) && (int'(count_y_ff) <= YMAX), "address counter left the display")

endmodule

// File: tb/lcd_gram_window_access_test.sv
// ----------------------------------------------------------------------------
// lcd_gram_window_access_test
// self-checking bench for the graphics ram port: pixel writes, reads and
// address commands are predicted against a local copy of the store and the
// windowed x/y counter, over several entry modes and window settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_gram_window_access_test;
   import lgwa_pkg::*;

   localparam int SCREEN_W  = SCREEN_WIDTH_DEF;
   localparam int SCREEN_H  = SCREEN_HEIGHT_DEF;
   localparam int RUN_LIMIT = 1000000;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ENTRY_MODE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // local copy of the block state
   logic [PIXEL_W-1:0] gram_model [SCREEN_W*SCREEN_H];
   int          cnt_x = 0;
   int          cnt_y = 0;
   int          shadow_x = 0;
   int          shadow_y = 0;
   logic [15:0] mode_reg = ENTRY_MODE_RST;
   int          win_x_first = 0;
   int          win_x_last = int'(WIN_X_LAST_RST);
   int          win_y_first = 0;
   int          win_y_last = int'(WIN_Y_LAST_RST);

   req_word_type host_words [$];
   rsp_word_type predicted_rsp [$];

   bit quiet_mode = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int long_hold_req = 0;
   int mismatches = 0;
   int cycle_count = 0;

   lcd_gram_window_access DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp(input int v, input int lim);
      return (v > lim) ? lim : v;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [15:0] rb_swap(input logic [15:0] v);
      if (mode_reg[EM_BGR_BIT])
         return v;
      return (v & 16'h07E0) | (v >> 11) | (v << 11);
   endfunction

   function automatic int gram_cell();
      return clamp(cnt_y, SCREEN_H - 1) * SCREEN_W + clamp(cnt_x, SCREEN_W - 1);
   endfunction

   // one step inside [first, last]; returns 1 on wrap
   function automatic bit step_axis(inout int pos, input bit up, input int first,
                                    input int last);
      if (up) begin
         if (pos + 1 > last) begin
            pos = first;
            return 1'b1;
         end
         pos = pos + 1;
      end else begin
         if (pos == 0 || pos - 1 < first) begin
            pos = last;
            return 1'b1;
         end
         pos = pos - 1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_word_type predict_gram(input req_word_type w);
      rsp_word_type r;
      int xf, xl, yf, yl;
      r.read_pixel = '0;
      xf = clamp(win_x_first, SCREEN_W - 1);
      xl = clamp(win_x_last, SCREEN_W - 1);
      yf = clamp(win_y_first, SCREEN_H - 1);
      yl = clamp(win_y_last, SCREEN_H - 1);
      case (w.cmd)
         CMD_WRITE: begin
            gram_model[gram_cell()] = rb_swap(w.value);
            if (mode_reg[EM_HORIZ_FIRST_BIT]) begin
               if (step_axis(cnt_x, mode_reg[EM_X_INC_BIT], xf, xl))
                  void'(step_axis(cnt_y, mode_reg[EM_Y_INC_BIT], yf, yl));
            end else begin
               if (step_axis(cnt_y, mode_reg[EM_Y_INC_BIT], yf, yl))
                  void'(step_axis(cnt_x, mode_reg[EM_X_INC_BIT], xf, xl));
            end
         end
         CMD_READ: begin
            r.read_pixel = rb_swap(gram_model[gram_cell()]);
         end
         CMD_SET_X: begin
            shadow_x = clamp(int'(w.value), SCREEN_W - 1);
            cnt_x = shadow_x;
            cnt_y = shadow_y;
         end
         default: begin
            shadow_y = clamp(int'(w.value), SCREEN_H - 1);
            cnt_x = shadow_x;
            cnt_y = shadow_y;
         end
      endcase
      r.addr_x = cnt_x[ADDR_X_W-1:0];
      r.addr_y = cnt_y[ADDR_Y_W-1:0];
      return r;
   endfunction

   // driver: next word goes out at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (host_words.size() != 0) begin
            req_data  <= host_words.pop_front();
            req_valid <= 1'b1;
            send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with an occasional long hold-off
   always @(negedge clock) begin
      int n;
      if (long_hold_req > 0) begin
         hold_left = long_hold_req;
         long_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         n = idle_len();
         if (n > 0) begin
            stall_left = n - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      rsp_word_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken)
         predicted_rsp.push_back(predict_gram(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: read_pixel=%h addr_x=%0d addr_y=%0d",
                        rsp_data.read_pixel, rsp_data.addr_x, rsp_data.addr_y);
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_data.read_pixel !== want.read_pixel || rsp_data.addr_x !== want.addr_x ||
                rsp_data.addr_y !== want.addr_y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pixel=%h x=%0d y=%0d, got pixel=%h x=%0d y=%0d",
                           want.read_pixel, want.addr_x, want.addr_y,
                           rsp_data.read_pixel, rsp_data.addr_x, rsp_data.addr_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_word(input cmd_type c, input logic [15:0] v);
      req_word_type w;
      w.cmd = c;
      w.value = v;
      host_words.push_back(w);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (host_words.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic load_config(input logic [15:0] em, input int xf, input int xl,
                              input int yf, input int yl);
      mode_reg    = em;
      win_x_first = xf;
      win_x_last  = xl;
      win_y_first = yf;
      win_y_last  = yl;
      csr_put(CSR_ENTRY_MODE, em);
      csr_put(CSR_WIN_X_FIRST, CSR_W'(xf));
      csr_put(CSR_WIN_X_LAST, CSR_W'(xl));
      csr_put(CSR_WIN_Y_FIRST, CSR_W'(yf));
      csr_put(CSR_WIN_Y_LAST, CSR_W'(yl));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // window edges most of the time, so wraps and carries come often
   function automatic logic [15:0] pick_coord(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return 16'(lo);
      if (r < 6)
         return 16'(hi);
      if (r < 9)
         return 16'($urandom_range(lo, hi));
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   task automatic gen_traffic(input int count);
      int made;
      int burst;
      int r;
      cmd_type c;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            // address set-up then a run of pixel traffic
            if ($urandom_range(0, 3) != 0)
               queue_word(CMD_SET_X, pick_coord(clamp(win_x_first, SCREEN_W - 1),
                                                clamp(win_x_last, SCREEN_W - 1)));
            queue_word(CMD_SET_Y, pick_coord(clamp(win_y_first, SCREEN_H - 1),
                                             clamp(win_y_last, SCREEN_H - 1)));
            made += 2;
            r = $urandom_range(0, 99);
            if (r < 70)
               burst = $urandom_range(1, 8);
            else if (r < 95)
               burst = $urandom_range(9, 40);
            else
               burst = $urandom_range(41, 330);
            for (int i = 0; i < burst && made < count; i++) begin
               if ($urandom_range(0, 3) == 0)
                  queue_word(CMD_READ, 16'($urandom_range(0, 16'hFFFF)));
               else
                  queue_word(CMD_WRITE, 16'($urandom_range(0, 16'hFFFF)));
               made++;
            end
         end else begin
            c = cmd_type'($urandom_range(0, 3));
            queue_word(c, 16'($urandom_range(0, 16'hFFFF)));
            made++;
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] em, input int xf, input int xl,
                            input int yf, input int yl, input int count);
      wait_drained();
      load_config(em, xf, xl, yf, yl);
      gen_traffic(count);
   endtask

   initial begin
      for (int i = 0; i < SCREEN_W * SCREEN_H; i++)
         gram_model[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // store clear runs after reset
      @(posedge clock);
      while (req_stall)
         @(posedge clock);

      // directed: reset mode, corners, saturation and the full-screen wrap
      queue_word(CMD_READ, 16'h0000);
      queue_word(CMD_WRITE, 16'hFFFF);
      queue_word(CMD_WRITE, 16'h0000);
      queue_word(CMD_SET_X, 16'd0);
      queue_word(CMD_READ, 16'hFFFF);
      queue_word(CMD_SET_X, 16'd319);
      queue_word(CMD_SET_Y, 16'd239);
      queue_word(CMD_WRITE, 16'hF800);
      queue_word(CMD_READ, 16'h0000);
      queue_word(CMD_SET_X, 16'hFFFF);
      queue_word(CMD_READ, 16'h0000);
      queue_word(CMD_SET_Y, 16'hFFFF);
      queue_word(CMD_SET_Y, 16'd240);
      queue_word(CMD_SET_X, 16'd320);
      queue_word(CMD_SET_X, 16'h01FF);
      queue_word(CMD_WRITE, 16'h001F);
      queue_word(CMD_WRITE, 16'h07E0);
      queue_word(CMD_SET_Y, 16'd0);
      queue_word(CMD_SET_X, 16'd318);
      queue_word(CMD_WRITE, 16'hAAAA);
      queue_word(CMD_WRITE, 16'h5555);
      queue_word(CMD_READ, 16'hFFFF);
      queue_word(CMD_SET_X, 16'd319);
      queue_word(CMD_READ, 16'h0000);

      // reset values written back, no idling on either side
      quiet_mode = 1'b1;
      run_phase(16'h1038, 0, 319, 0, 239, 215);
      wait_drained();
      quiet_mode = 1'b0;

      // vertical first, both decrementing, swapped colors; sender pauses midway
      run_phase(16'h0000, 10, 17, 20, 25, 105);
      wait_drained();
      gen_traffic(110);

      // all bits set, corner window; receiver holds off to fill the block
      wait_drained();
      load_config(16'hFFFF, 300, 319, 230, 239);
      long_hold_req = 400;
      gen_traffic(215);

      run_phase(16'h0008, 100, 100, 50, 50, 215);
      run_phase(16'h0030, 200, 150, 120, 100, 215);
      run_phase(16'h1010, 400, 511, 250, 255, 215);
      run_phase(16'h1028, 0, 3, 0, 2, 215);
      run_phase(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 511)),
                int'($urandom_range(0, 511)), int'($urandom_range(0, 255)),
                int'($urandom_range(0, 255)), 215);
      run_phase(16'hEFC7, 0, 319, 0, 239, 215);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_rsp.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/lgwa_pkg.sv
src/lcd_gram_window_access.sv
tb/lcd_gram_window_access_test.sv
